// ===== rtl/u8u16_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_end;
  } out_item_t;

  // What follows the replacement units of one byte's output run
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_ONE  = 2'd1,
    TAIL_PAIR = 2'd2
  } tail_kind_t;

  // One byte's worth of output, handed from front to back
  typedef struct packed {
    logic [2:0]  repl_cnt;
    tail_kind_t  tail;
    logic [20:0] point;
    logic        fin;
  } unit_desc_t;

  // Expected sequence lengths; zero means no sequence open
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  localparam logic [15:0] UNIT_REPL  = 16'hFFFD;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [20:0] MIN_2B     = 21'h00080;
  localparam logic [20:0] MIN_3B     = 21'h00800;
  localparam logic [20:0] SURR_FIRST = 21'h0D800;
  localparam logic [20:0] SURR_LAST  = 21'h0DFFF;
  localparam logic [20:0] BMP_MAX    = 21'h0FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] MAX_POINT  = 21'h10FFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  function automatic logic [1:0] tail_units(tail_kind_t kind);
    logic [1:0] n;
    unique case (kind)
      TAIL_ONE:  n = 2'd1;
      TAIL_PAIR: n = 2'd2;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/u8u16_front.sv =====
// Front end: tracks the open UTF-8 sequence and turns each byte into a unit descriptor.
`timescale 1ns / 1ps

module u8u16_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  q_full,
  input  u8u16_pkg::in_item_t   in_data,
  output logic                  push,
  output u8u16_pkg::unit_desc_t desc
);

  logic [2:0]  len_r, len_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [20:0] partial_r, partial_nxt;

  logic        accept;
  logic        is_cont;
  logic        seq_open;
  logic        point_ok;
  logic [20:0] shifted;
  logic [2:0]  seen_inc;
  logic [7:0]  b;
  logic        fin;
  logic [2:0]  unit_cnt;

  assign accept = in_valid && !q_full;
  assign b      = in_data.text_byte;
  assign fin    = in_data.final_byte;

  always_comb begin
    is_cont  = (b[7:6] == 2'b10);
    seq_open = (len_r != u8u16_pkg::LEN_NONE);
    shifted  = {partial_r[14:0], b[5:0]};
    seen_inc = seen_r + 3'd1;

    unique case (len_r)
      u8u16_pkg::LEN_2: point_ok = (shifted >= u8u16_pkg::MIN_2B);
      u8u16_pkg::LEN_3: point_ok = (shifted >= u8u16_pkg::MIN_3B) &&
                                   !((shifted >= u8u16_pkg::SURR_FIRST) &&
                                     (shifted <= u8u16_pkg::SURR_LAST));
      u8u16_pkg::LEN_4: point_ok = (shifted >= u8u16_pkg::SUPP_BASE) &&
                                   (shifted <= u8u16_pkg::MAX_POINT);
      default:          point_ok = 1'b0;
    endcase

    desc          = '0;
    desc.tail     = u8u16_pkg::TAIL_NONE;
    desc.fin      = fin;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    partial_nxt   = partial_r;

    if (seq_open && is_cont) begin
      partial_nxt = shifted;
      seen_nxt    = seen_inc;
      if (seen_inc >= len_r) begin
        if (point_ok) begin
          desc.point = shifted;
          desc.tail  = (shifted > u8u16_pkg::BMP_MAX) ? u8u16_pkg::TAIL_PAIR
                                                      : u8u16_pkg::TAIL_ONE;
        end else begin
          desc.repl_cnt = seen_inc;
        end
        len_nxt     = u8u16_pkg::LEN_NONE;
        seen_nxt    = 3'd0;
        partial_nxt = '0;
      end else if (fin) begin
        desc.repl_cnt = seen_inc;
      end
    end else begin
      // broken sequence: flush what was taken, then treat byte as a lead
      desc.repl_cnt = seq_open ? seen_r : 3'd0;
      len_nxt       = u8u16_pkg::LEN_NONE;
      seen_nxt      = 3'd0;
      partial_nxt   = '0;
      if (!b[7]) begin
        desc.tail  = u8u16_pkg::TAIL_ONE;
        desc.point = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        len_nxt     = u8u16_pkg::LEN_2;
        seen_nxt    = 3'd1;
        partial_nxt = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        len_nxt     = u8u16_pkg::LEN_3;
        seen_nxt    = 3'd1;
        partial_nxt = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        len_nxt     = u8u16_pkg::LEN_4;
        seen_nxt    = 3'd1;
        partial_nxt = {18'd0, b[2:0]};
      end else begin
        desc.repl_cnt = desc.repl_cnt + 3'd1;
      end
      // lead that opens a sequence on the last byte is cut short at once
      if (fin && (len_nxt != u8u16_pkg::LEN_NONE)) begin
        desc.repl_cnt = desc.repl_cnt + 3'd1;
      end
    end

    if (fin) begin
      len_nxt     = u8u16_pkg::LEN_NONE;
      seen_nxt    = 3'd0;
      partial_nxt = '0;
    end

    unit_cnt = desc.repl_cnt + {1'b0, u8u16_pkg::tail_units(desc.tail)};
  end

  // bytes that give no unit update state only
  assign push = accept && (unit_cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= u8u16_pkg::LEN_NONE;
      seen_r    <= 3'd0;
      partial_r <= '0;
    end else if (accept) begin
      len_r     <= len_nxt;
      seen_r    <= seen_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// ===== rtl/u8u16_queue.sv =====
// Small descriptor queue between front and back ends.
`timescale 1ns / 1ps

module u8u16_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u8u16_pkg::unit_desc_t push_desc,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output u8u16_pkg::unit_desc_t head
);

  localparam int AW = u8u16_pkg::QUEUE_AW;
  localparam int DEPTH = u8u16_pkg::QUEUE_DEPTH;

  u8u16_pkg::unit_desc_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== rtl/u8u16_back.sv =====
// Back end: expands each descriptor into UTF-16 code units, one per cycle while out_stall does not hold them.
`timescale 1ns / 1ps

module u8u16_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  u8u16_pkg::unit_desc_t head,
  input  logic                  out_stall,
  output logic                  pop,
  output logic                  out_valid,
  output u8u16_pkg::out_item_t  out_data
);

  logic [2:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  u8u16_pkg::out_item_t out_data_r, out_data_nxt;

  logic [2:0]  total;
  logic [20:0] supp;
  logic [15:0] unit;
  logic        last;
  logic        advance;

  always_comb begin
    total = head.repl_cnt + {1'b0, u8u16_pkg::tail_units(head.tail)};
    supp  = head.point - u8u16_pkg::SUPP_BASE;
    last  = (idx_r == total - 3'd1);

    if (idx_r < head.repl_cnt) begin
      unit = u8u16_pkg::UNIT_REPL;
    end else begin
      case (head.tail)
        u8u16_pkg::TAIL_ONE:  unit = head.point[15:0];
        u8u16_pkg::TAIL_PAIR: unit = (idx_r == head.repl_cnt)
                                     ? (u8u16_pkg::HI_SURR | {6'd0, supp[19:10]})
                                     : (u8u16_pkg::LO_SURR | {6'd0, supp[9:0]});
        default:              unit = u8u16_pkg::UNIT_REPL;
      endcase
    end

    advance = head_valid && (!out_valid_r || !out_stall);

    out_data_nxt.code_unit = unit;
    out_data_nxt.run_last  = last;
    out_data_nxt.text_end  = last && head.fin;

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    if (advance) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  assign pop       = advance && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== rtl/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 byte stream to UTF-16 code unit decoder, top level.
// With the back end idle, a byte's descriptor is written into the queue when the byte is taken,
//   and the back end then places its first unit in the registered out_data/out_valid outputs.
// Throughput: one byte per cycle while bytes give at most one unit and out_stall is low; a byte
//   giving k units holds the back end until all k are sent, one unit per output transaction;
//   in_stall rises only while the 2-deep queue between front and back holds two descriptors.
// Reset (rst_n low, synchronous): no sequence open, queue empty, out_valid low.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u8u16_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8u16_pkg::out_item_t out_data
);

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_valid;
  u8u16_pkg::unit_desc_t push_desc;
  u8u16_pkg::unit_desc_t head_desc;

  assign in_stall = q_full;

  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_data  (in_data),
    .push     (q_push),
    .desc     (push_desc)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head_desc)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (head_desc),
    .out_stall  (out_stall),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // a descriptor is retired only from a non-empty queue
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("descriptor retired from empty queue");

  // the front never queues a byte that gives no unit
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ((push_desc.repl_cnt != 3'd0) ||
                (push_desc.tail != u8u16_pkg::TAIL_NONE)))
    else $error("empty descriptor queued");

  // the end of the text always closes a byte's run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.text_end) |-> out_data.run_last)
    else $error("text end flagged inside a run");

endmodule

// ===== dv/utf8_to_utf16_decoder_unit_tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 decoder unit.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit_tb;

  localparam int RANDOM_BYTES = 280;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTED  = 100;
  localparam int DIRECTED_N   = 26;

  // One directed transaction; fixed rows carry their single expected unit
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        final_byte;
    logic        fixed;
    logic [15:0] unit;
  } dir_row_t;

  typedef enum int {
    CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_MALFORMED, CH_CUT, CH_NOISE
  } char_kind_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  u8u16_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  u8u16_pkg::out_item_t out_data;

  // Decoder state mirrored by the predictor
  logic [2:0]  open_len;
  logic [2:0]  open_cnt;
  logic [20:0] open_point;

  logic [15:0]          run_units[$];
  u8u16_pkg::out_item_t expected_units[$];
  logic [7:0]           text_bytes[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int bytes_sent  = 0;

  dir_row_t directed_rows [DIRECTED_N] = '{
    '{8'h00, 1'b0, 1'b1, 16'h0000},              // lowest byte
    '{8'h7F, 1'b1, 1'b1, 16'h007F},              // highest ASCII, closes a text
    '{8'h80, 1'b0, 1'b1, u8u16_pkg::UNIT_REPL},  // stray continuation
    '{8'hFF, 1'b0, 1'b1, u8u16_pkg::UNIT_REPL},  // never a lead
    '{8'hC2, 1'b0, 1'b0, 16'h0000},              // smallest two-byte value
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 16'h0000},
    '{8'h82, 1'b0, 1'b0, 16'h0000},
    '{8'hAC, 1'b0, 1'b0, 16'h0000},
    '{8'hF4, 1'b0, 1'b0, 16'h0000},              // largest code point, surrogate pair
    '{8'h8F, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hBF, 1'b0, 1'b0, 16'h0000},
    '{8'hC0, 1'b0, 1'b0, 16'h0000},              // overlong
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hED, 1'b0, 1'b0, 16'h0000},              // encoded surrogate
    '{8'hA0, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hF4, 1'b0, 1'b0, 16'h0000},              // above the last code point
    '{8'h90, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'h80, 1'b0, 1'b0, 16'h0000},
    '{8'hE2, 1'b0, 1'b0, 16'h0000},              // sequence broken by a new lead
    '{8'h41, 1'b0, 1'b0, 16'h0000},
    '{8'hF0, 1'b0, 1'b0, 16'h0000},              // text ends inside a sequence
    '{8'h9F, 1'b1, 1'b0, 16'h0000}
  };

  utf8_to_utf16_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_unit(logic [15:0] u);
    if (run_units.size() < 4) run_units = {run_units, u};
  endfunction

  function automatic void add_expected(u8u16_pkg::out_item_t u);
    expected_units = {expected_units, u};
  endfunction

  function automatic void clear_open();
    open_len   = u8u16_pkg::LEN_NONE;
    open_cnt   = 3'd0;
    open_point = 21'd0;
  endfunction

  // One replacement per byte taken so far
  function automatic void flush_open();
    for (int k = 0; k < open_cnt && k < 4; k++) put_unit(u8u16_pkg::UNIT_REPL);
    clear_open();
  endfunction

  function automatic logic point_allowed(logic [2:0] len, logic [20:0] p);
    case (len)
      u8u16_pkg::LEN_2: return p >= u8u16_pkg::MIN_2B;
      u8u16_pkg::LEN_3: return p >= u8u16_pkg::MIN_3B &&
                               !(p >= u8u16_pkg::SURR_FIRST && p <= u8u16_pkg::SURR_LAST);
      u8u16_pkg::LEN_4: return p >= u8u16_pkg::SUPP_BASE && p <= u8u16_pkg::MAX_POINT;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic void put_point(logic [20:0] p);
    logic [20:0] v;
    if (p <= u8u16_pkg::BMP_MAX) begin
      put_unit(p[15:0]);
    end else begin
      v = p - u8u16_pkg::SUPP_BASE;
      put_unit(u8u16_pkg::HI_SURR + {6'd0, v[19:10]});
      put_unit(u8u16_pkg::LO_SURR + {6'd0, v[9:0]});
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic taken;
    run_units.delete();
    taken = 1'b0;
    if (open_len != u8u16_pkg::LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        taken      = 1'b1;
        open_point = {open_point[14:0], b[5:0]};
        open_cnt   = open_cnt + 3'd1;
        if (open_cnt >= open_len) begin
          if (point_allowed(open_len, open_point)) begin
            put_point(open_point);
            clear_open();
          end else begin
            flush_open();
          end
        end else if (fin) begin
          flush_open();
        end
      end else begin
        flush_open();
      end
    end
    if (!taken) begin
      if (!b[7]) begin
        put_unit({8'h00, b});
      end else if (b[7:5] == 3'b110) begin
        open_len = u8u16_pkg::LEN_2; open_cnt = 3'd1; open_point = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        open_len = u8u16_pkg::LEN_3; open_cnt = 3'd1; open_point = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        open_len = u8u16_pkg::LEN_4; open_cnt = 3'd1; open_point = {18'd0, b[2:0]};
      end else begin
        put_unit(u8u16_pkg::UNIT_REPL);
      end
      if (fin && open_len != u8u16_pkg::LEN_NONE) flush_open();
    end
    if (fin) clear_open();
  endfunction

  function automatic void expect_run(logic fin);
    u8u16_pkg::out_item_t u;
    foreach (run_units[i]) begin
      u.code_unit = run_units[i];
      u.run_last  = (i == run_units.size() - 1);
      u.text_end  = u.run_last & fin;
      add_expected(u);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(u8u16_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic feed_byte(logic [7:0] b, logic fin, logic fixed, logic [15:0] unit);
    u8u16_pkg::in_item_t  it;
    u8u16_pkg::out_item_t u;
    it.text_byte  = b;
    it.final_byte = fin;
    send_byte(it);
    decode_byte(b, fin);
    if (fixed) begin
      u.code_unit = unit;
      u.run_last  = 1'b1;
      u.text_end  = fin;
      add_expected(u);
    end else begin
      expect_run(fin);
    end
    bytes_sent++;
  endtask

  function automatic void add_text_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void encode_point(logic [20:0] cp, int len);
    case (len)
      2: begin
        add_text_byte({3'b110, cp[10:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_text_byte({4'b1110, cp[15:12]});
        add_text_byte({2'b10, cp[11:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_text_byte({5'b11110, cp[20:18]});
        add_text_byte({2'b10, cp[17:12]});
        add_text_byte({2'b10, cp[11:6]});
        add_text_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] legal_point(int len);
    logic [20:0] cp;
    case (len)
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        while (cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST)
          cp = 21'($urandom_range('h800, 'hFFFF));
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Mostly well-formed characters, with some malformed, cut and noise bytes
  task automatic send_text();
    int          r;
    int          len;
    int          cut;
    char_kind_t  kind;
    logic [20:0] cp;
    text_bytes.delete();
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 19);
      kind = (r < 5)  ? CH_ASCII :
             (r < 9)  ? CH_TWO :
             (r < 12) ? CH_THREE :
             (r < 15) ? CH_FOUR :
             (r < 17) ? CH_MALFORMED :
             (r < 19) ? CH_CUT : CH_NOISE;
      case (kind)
        CH_ASCII: add_text_byte(8'($urandom_range(0, 'h7F)));
        CH_TWO:   encode_point(legal_point(2), 2);
        CH_THREE: encode_point(legal_point(3), 3);
        CH_FOUR:  encode_point(legal_point(4), 4);
        CH_MALFORMED: begin
          case ($urandom_range(0, 2))
            0: begin
              len = 3;
              cp  = 21'($urandom_range('hD800, 'hDFFF));
            end
            1: begin
              len = 4;
              cp  = 21'($urandom_range('h110000, 'h1FFFFF));
            end
            default: begin
              len = $urandom_range(2, 4);
              cp  = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
            end
          endcase
          encode_point(cp, len);
        end
        CH_CUT: begin
          len = $urandom_range(2, 4);
          encode_point(legal_point(len), len);
          cut = $urandom_range(1, len - 1);
          repeat (cut) void'(text_bytes.pop_back());
        end
        default: add_text_byte(8'($urandom_range(0, 255)));
      endcase
    end
    foreach (text_bytes[i]) feed_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, 16'h0000);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_open();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      feed_byte(directed_rows[i].text_byte, directed_rows[i].final_byte,
                directed_rows[i].fixed, directed_rows[i].unit);
    while (bytes_sent < DIRECTED_N + RANDOM_BYTES) send_text();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    stall_mode_t mode;
    int          left;
    int          phase;
    out_stall = 1'b0;
    mode  = STALL_NONE;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(8, 64);
      end
      left--;
      phase++;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
        STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default:     out_stall <= (phase % 5) < 3;
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0d ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_units
    u8u16_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected transaction", out_data.code_unit, 16'h0000);
      end else begin
        want = expected_units.pop_front();
        if (out_data.code_unit !== want.code_unit)
          report_mismatch("code_unit", out_data.code_unit, want.code_unit);
        if (out_data.run_last !== want.run_last)
          report_mismatch("run_last", {15'd0, out_data.run_last}, {15'd0, want.run_last});
        if (out_data.text_end !== want.text_end)
          report_mismatch("text_end", {15'd0, out_data.text_end}, {15'd0, want.text_end});
      end
    end
  end

  // Ends the run when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
